FILE: hw/rtl/mee_pkg.sv
// ----------------------------------------------------------------------------
// mee_pkg
// Shared types, codes and helpers of the MIDI event message encoder.
// ----------------------------------------------------------------------------
package mee_pkg;

   localparam int QueueDepthDefault  = 16;
   localparam int CoarseShiftDefault = 9;
   localparam int FineShiftDefault   = 2;
   localparam int VolumeMaxDefault   = 65535;

   localparam int MaxBytes = 12;

   localparam logic [2:0] KIND_NOTE_ON     = 3'd0;
   localparam logic [2:0] KIND_NOTE_CHANGE = 3'd1;
   localparam logic [2:0] KIND_NOTE_OFF    = 3'd2;
   localparam logic [2:0] KIND_BREATH      = 3'd3;
   localparam logic [2:0] KIND_FLUSH       = 3'd4;
   localparam logic [2:0] KIND_BEND        = 3'd5;
   localparam logic [2:0] KIND_CONTROLLER  = 3'd6;
   localparam logic [2:0] KIND_TICK        = 3'd7;

   localparam logic [2:0] CSR_MIDI_CHANNEL  = 3'd0;
   localparam logic [2:0] CSR_VOLUME_CTRL   = 3'd1;
   localparam logic [2:0] CSR_FINE_ENABLE   = 3'd2;
   localparam logic [2:0] CSR_FIXED_VEL     = 3'd3;
   localparam logic [2:0] CSR_REPEAT_ENABLE = 3'd4;
   localparam logic [2:0] CSR_REPEAT_DELAY  = 3'd5;
   localparam logic [2:0] CSR_OVERRIDE      = 3'd6;

   localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
   localparam logic [7:0] ST_NOTE_ON    = 8'h90;
   localparam logic [7:0] ST_CONTROL    = 8'hB0;
   localparam logic [7:0] ST_AFTERTOUCH = 8'hD0;
   localparam logic [7:0] ST_BEND       = 8'hE0;

   typedef struct packed {
      logic [8*MaxBytes-1:0] vec;
      logic [3:0]            cnt;
   } msg_type;

   function automatic msg_type msg(input logic [23:0] d, input logic [3:0] n);
      msg_type r;
      r.vec = {{(8*MaxBytes-24){1'b0}}, d};
      r.cnt = n;
      return r;
   endfunction

   function automatic msg_type join_msg(input msg_type a, input msg_type b);
      msg_type r;
      r.vec = (a.vec << {b.cnt, 3'b000}) | b.vec;
      r.cnt = a.cnt + b.cnt;
      return r;
   endfunction

endpackage

FILE: hw/rtl/mee_front.sv
// ----------------------------------------------------------------------------
// mee_front
// Accepts events, keeps note, volume, bend and repeat ring state, and forms
// the byte word of each event.
// ----------------------------------------------------------------------------
module mee_front #(
   parameter int QUEUE_DEPTH  = mee_pkg::QueueDepthDefault,
   parameter int COARSE_SHIFT = mee_pkg::CoarseShiftDefault,
   parameter int FINE_SHIFT   = mee_pkg::FineShiftDefault,
   parameter int VOLUME_MAX   = mee_pkg::VolumeMaxDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic                  req_valid,
   input  logic                  full,
   input  logic [2:0]            req_kind,
   input  logic [6:0]            req_note_number,
   input  logic signed [16:0]    req_value,
   input  logic [6:0]            req_controller_number,
   output logic                  push,
   output mee_pkg::msg_type      word
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PW-1:0] PLAST = PW'(QUEUE_DEPTH - 1);
   localparam logic signed [16:0] VMAX = 17'(VOLUME_MAX);

   logic [4:0]        ch_ff;
   logic signed [7:0] vc_ff;
   logic              fine_ff, rep_ff, ovr_ff;
   logic [6:0]        fixv_ff;
   logic [15:0]       delay_ff;

   logic signed [7:0]  note_ff, note_in;
   logic [15:0]        breath_ff, breath_in, flushed_ff, flushed_in;
   logic [6:0]         lc_ff, lc_in, lf_ff, lf_in;
   logic signed [13:0] bin_ff, bin_in;
   logic [13:0]        bsent_ff, bsent_in;
   logic [31:0]        time_ff, time_in;
   logic [PW-1:0]      rp_ff, rp_in, wp_ff, wp_in;

   logic [7:0]  note_mem [QUEUE_DEPTH];
   logic [31:0] time_mem [QUEUE_DEPTH];
   logic [7:0]  rd_note_ff;
   logic [31:0] rd_time_ff;

   logic              accept, ring_we;
   logic [31:0]       ring_time;
   logic signed [16:0] vol_src;
   logic [6:0]        msb, lsb;
   mee_pkg::msg_type  vacc, acc;
   logic [6:0]        vlc, vlf, vel;
   logic signed [17:0] v18;
   logic signed [13:0] bsat;
   logic [13:0]       bu;
   logic [6:0]        ccv;
   logic [31:0]       diff;
   logic [7:0]        vcp;

   function automatic logic [7:0] status(input logic [7:0] base, input logic [4:0] c);
      return base + {3'b000, c} - 8'd1;
   endfunction

   assign accept = req_valid && !full;
   assign vcp = vc_ff + 8'd32;

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff    <= 5'd1;
         vc_ff    <= 8'sd2;
         fine_ff  <= 1'b0;
         fixv_ff  <= 7'd0;
         rep_ff   <= 1'b1;
         delay_ff <= 16'd1000;
         ovr_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            mee_pkg::CSR_MIDI_CHANNEL:  ch_ff    <= csr_data[4:0];
            mee_pkg::CSR_VOLUME_CTRL:   vc_ff    <= csr_data[7:0];
            mee_pkg::CSR_FINE_ENABLE:   fine_ff  <= csr_data[0];
            mee_pkg::CSR_FIXED_VEL:     fixv_ff  <= csr_data[6:0];
            mee_pkg::CSR_REPEAT_ENABLE: rep_ff   <= csr_data[0];
            mee_pkg::CSR_REPEAT_DELAY:  delay_ff <= csr_data;
            mee_pkg::CSR_OVERRIDE:      ovr_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      vol_src = (req_kind == mee_pkg::KIND_NOTE_OFF) ? 17'sd0 :
                (req_kind == mee_pkg::KIND_FLUSH) ? $signed({1'b0, breath_ff}) : req_value;
      msb  = 7'(vol_src >>> COARSE_SHIFT);
      lsb  = 7'(vol_src >>> FINE_SHIFT);
      vacc = '0;
      vlc  = lc_ff;
      vlf  = lf_ff;
      if (note_ff >= 0) begin
         if (vc_ff > 0) begin
            if (lc_ff != msb)
               vacc = mee_pkg::join_msg(vacc, mee_pkg::msg({status(mee_pkg::ST_CONTROL,
                  ch_ff), vc_ff, 1'b0, msb}, 4'd3));
            if (fine_ff) begin
               if (lf_ff != lsb)
                  vacc = mee_pkg::join_msg(vacc, mee_pkg::msg({status(mee_pkg::ST_CONTROL,
                     ch_ff), vcp, 1'b0, lsb}, 4'd3));
               vlf = lsb;
            end
         end else if (vc_ff == 0) begin
            if (lc_ff != msb)
               vacc = mee_pkg::msg({8'h00, status(mee_pkg::ST_AFTERTOUCH, ch_ff), 1'b0, msb},
                  4'd2);
         end
         vlc = msb;
      end

      note_in    = note_ff;
      breath_in  = breath_ff;
      flushed_in = flushed_ff;
      lc_in      = lc_ff;
      lf_in      = lf_ff;
      bin_in     = bin_ff;
      bsent_in   = bsent_ff;
      time_in    = time_ff;
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      ring_we    = 1'b0;
      ring_time  = time_ff + {16'h0000, delay_ff};
      acc        = '0;
      vel        = 7'd0;
      v18        = 18'sd0;
      bsat       = 14'sd0;
      bu         = 14'd0;
      ccv        = 7'd0;
      diff       = 32'd0;

      if (accept) begin
         unique case (req_kind)
            mee_pkg::KIND_NOTE_ON: begin
               if (ovr_ff) begin
                  note_in = {1'b0, req_note_number};
               end else begin
                  if (note_ff > 0)
                     acc = mee_pkg::msg({status(mee_pkg::ST_NOTE_OFF, ch_ff), 1'b0,
                        note_ff[6:0], 8'h00}, 4'd3);
                  acc   = mee_pkg::join_msg(acc, vacc);
                  lc_in = vlc;
                  lf_in = vlf;
                  v18   = 18'(req_value >>> COARSE_SHIFT) + 18'sd1;
                  if (v18 > 18'sd127) v18 = 18'sd127;
                  vel = (fixv_ff != 7'd0) ? fixv_ff : v18[6:0];
                  acc = mee_pkg::join_msg(acc, mee_pkg::msg({status(mee_pkg::ST_NOTE_ON,
                     ch_ff), 1'b0, req_note_number, 1'b0, vel}, 4'd3));
                  note_in = {1'b0, req_note_number};
               end
            end
            mee_pkg::KIND_NOTE_CHANGE: begin
               ring_we = rep_ff;
               vel = (fixv_ff != 7'd0) ? fixv_ff : 7'(req_value >>> COARSE_SHIFT);
               acc = mee_pkg::msg({status(mee_pkg::ST_NOTE_ON, ch_ff), 1'b0, req_note_number,
                  1'b0, vel}, 4'd3);
               if (note_ff > 0)
                  acc = mee_pkg::join_msg(acc, mee_pkg::msg({status(mee_pkg::ST_NOTE_OFF,
                     ch_ff), 1'b0, note_ff[6:0], 1'b0, vel}, 4'd3));
               note_in = {1'b0, req_note_number};
            end
            mee_pkg::KIND_NOTE_OFF: begin
               breath_in = 16'd0;
               acc   = vacc;
               lc_in = vlc;
               lf_in = vlf;
               if (note_ff > 0)
                  acc = mee_pkg::join_msg(acc, mee_pkg::msg({status(mee_pkg::ST_NOTE_OFF,
                     ch_ff), 1'b0, note_ff[6:0], 8'h00}, 4'd3));
               ring_we = rep_ff;
               note_in = -8'sd1;
            end
            mee_pkg::KIND_BREATH: begin
               if (req_value < 0) breath_in = 16'd0;
               else if (req_value > VMAX) breath_in = VMAX[15:0];
               else breath_in = req_value[15:0];
            end
            mee_pkg::KIND_FLUSH: begin
               if (flushed_ff != breath_ff) begin
                  acc        = vacc;
                  lc_in      = vlc;
                  lf_in      = vlf;
                  flushed_in = breath_ff;
               end
            end
            mee_pkg::KIND_BEND: begin
               if (req_value < -17'sd8192) bsat = -14'sd8192;
               else if (req_value > 17'sd8191) bsat = 14'sd8191;
               else bsat = req_value[13:0];
               bu = bsat + 14'h2000;
               if (bsat != bin_ff) begin
                  bin_in = bsat;
                  if (bu != bsent_ff) begin
                     bsent_in = bu;
                     acc = mee_pkg::msg({status(mee_pkg::ST_BEND, ch_ff), 1'b0, bu[6:0],
                        1'b0, bu[13:7]}, 4'd3);
                  end
               end
            end
            mee_pkg::KIND_CONTROLLER: begin
               if (req_value < 0) ccv = 7'd0;
               else if (req_value > 17'sd127) ccv = 7'd127;
               else ccv = req_value[6:0];
               acc = mee_pkg::msg({status(mee_pkg::ST_CONTROL, ch_ff), 1'b0,
                  req_controller_number, 1'b0, ccv}, 4'd3);
            end
            mee_pkg::KIND_TICK: begin
               time_in = time_ff + 32'd1;
               diff    = time_in - rd_time_ff;
               if (rp_ff != wp_ff && !diff[31]) begin
                  rp_in = (rp_ff == PLAST) ? '0 : rp_ff + 1'b1;
                  if ($signed(rd_note_ff) > 0 && $signed(rd_note_ff) != note_ff)
                     acc = mee_pkg::msg({status(mee_pkg::ST_NOTE_OFF, ch_ff), 1'b0,
                        rd_note_ff[6:0], 8'h00}, 4'd3);
               end
            end
            default: ;
         endcase
         if (ring_we) wp_in = (wp_ff == PLAST) ? '0 : wp_ff + 1'b1;
      end
   end

   assign push = accept && (acc.cnt != 4'd0);
   assign word = acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff    <= -8'sd1;
         breath_ff  <= 16'd0;
         flushed_ff <= 16'd0;
         lc_ff      <= 7'd0;
         lf_ff      <= 7'd0;
         bin_ff     <= 14'sd0;
         bsent_ff   <= 14'd0;
         time_ff    <= 32'd0;
         rp_ff      <= '0;
         wp_ff      <= '0;
      end else begin
         note_ff    <= note_in;
         breath_ff  <= breath_in;
         flushed_ff <= flushed_in;
         lc_ff      <= lc_in;
         lf_ff      <= lf_in;
         bin_ff     <= bin_in;
         bsent_ff   <= bsent_in;
         time_ff    <= time_in;
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         note_mem[wp_ff] <= note_ff;
         time_mem[wp_ff] <= ring_time;
      end
      if (ring_we && wp_ff == rp_in) begin
         rd_note_ff <= note_ff;
         rd_time_ff <= ring_time;
      end else begin
         rd_note_ff <= note_mem[rp_in];
         rd_time_ff <= time_mem[rp_in];
      end
   end

endmodule

FILE: hw/rtl/mee_fifo.sv
// ----------------------------------------------------------------------------
// mee_fifo
// Two-entry queue of byte words between the front and the back.
// ----------------------------------------------------------------------------
module mee_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mee_pkg::msg_type push_word,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output mee_pkg::msg_type head
);

   logic [1:0]       cnt_ff, cnt_in;
   mee_pkg::msg_type slot0_ff, slot1_ff;
   logic             to_slot0;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = slot0_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign to_slot0  = push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (to_slot0) slot0_ff <= push_word;
      else if (pop) slot0_ff <= slot1_ff;
      if (push && !to_slot0) slot1_ff <= push_word;
   end

endmodule

FILE: hw/rtl/mee_back.sv
// ----------------------------------------------------------------------------
// mee_back
// Takes byte words from the queue and sends them one byte at a time.
// ----------------------------------------------------------------------------
module mee_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             not_empty,
   input  mee_pkg::msg_type head,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [7:0]       rsp_midi_byte,
   output logic             rsp_last_byte
);

   mee_pkg::msg_type word_ff;
   logic [3:0]       rem_ff, rem_in;
   logic             valid_ff, valid_in, advance;
   logic [7:0]       byte_ff;
   logic             last_ff;

   assign advance = !valid_ff || !rsp_stall;
   assign pop     = not_empty && (rem_ff == 4'd0 || (rem_ff == 4'd1 && advance));

   always_comb begin
      rem_in   = rem_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = rem_ff != 4'd0;
         if (rem_ff != 4'd0) rem_in = rem_ff - 4'd1;
      end
      if (pop) rem_in = head.cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) word_ff <= head;
      if (advance && rem_ff != 4'd0) begin
         byte_ff <= word_ff.vec[{rem_ff - 4'd1, 3'b000} +: 8];
         last_ff <= rem_ff == 4'd1;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_midi_byte = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

FILE: hw/rtl/midi_event_message_encoder.sv
// ----------------------------------------------------------------------------
// midi_event_message_encoder
// Instrument events in, serial MIDI bytes out.
// ----------------------------------------------------------------------------
// Each event is taken when the queue is not full and turned into up to twelve
// MIDI bytes, which leave one per cycle while rsp_stall is low, with last_byte
// marking the final byte of the event. A two-word queue lets a following event
// be taken while earlier bytes drain, and events that produce no bytes (breath,
// unchanged bend or flush, quiet ticks) put no word in the queue. Configuration
// is to be written only while idle by the user; the block does not enforce it.
module midi_event_message_encoder #(
   parameter int QUEUE_DEPTH  = mee_pkg::QueueDepthDefault,
   parameter int COARSE_SHIFT = mee_pkg::CoarseShiftDefault,
   parameter int FINE_SHIFT   = mee_pkg::FineShiftDefault,
   parameter int VOLUME_MAX   = mee_pkg::VolumeMaxDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic [6:0]         req_note_number,
   input  logic signed [16:0] req_value,
   input  logic [6:0]         req_controller_number,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_midi_byte,
   output logic               rsp_last_byte
);

   logic             push, pop, full, not_empty;
   mee_pkg::msg_type word, head;

   assign req_stall = full;

   mee_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH), .COARSE_SHIFT(COARSE_SHIFT),
      .FINE_SHIFT(FINE_SHIFT), .VOLUME_MAX(VOLUME_MAX)
   ) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_valid, .full,
      .req_kind, .req_note_number, .req_value, .req_controller_number,
      .push, .word
   );

   mee_fifo u_fifo (
      .clock, .reset, .push, .push_word(word), .pop, .full, .not_empty, .head
   );

   mee_back u_back (
      .clock, .reset, .not_empty, .head, .pop, .rsp_stall, .rsp_valid,
      .rsp_midi_byte, .rsp_last_byte
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI event message encoder: random and directed
// events are driven through the request channel, each output byte is checked
// against a behavioural predictor, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [2:0]         kind;
      logic [6:0]         note;
      logic signed [16:0] value;
      logic [6:0]         ctrl;
   } req_word_type;

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       last;
   } rsp_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_kind = '0;
   logic [6:0]         req_note_number = '0;
   logic signed [16:0] req_value = '0;
   logic [6:0]         req_controller_number = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_midi_byte;
   logic               rsp_last_byte;

   midi_event_message_encoder uut (.*);

   // predictor state and configuration
   int unsigned m_chan, m_fine_en, m_fix_vel, m_rep_en, m_rep_delay, m_override;
   int          m_vol_ctrl;
   int          m_note, m_breath, m_flushed, m_coarse, m_fine, m_bend_in, m_bend_sent;
   logic [31:0] m_time;
   logic [7:0]  m_ring_note [mee_pkg::QueueDepthDefault];
   logic [31:0] m_ring_time [mee_pkg::QueueDepthDefault];
   int unsigned m_rd, m_wr;

   req_word_type pending_events[$];
   rsp_word_type expected_bytes[$];
   rsp_word_type ev_bytes[$];
   int           fail_count = 0;
   longint       cycle_count = 0;

   function automatic int shr(int v, int s);
      return v >>> s;
   endfunction

   function automatic void put(int b);
      if (ev_bytes.size() < mee_pkg::MaxBytes) ev_bytes.push_back('{b[7:0], 1'b0});
   endfunction

   function automatic void put_status(logic [7:0] base);
      put((base + m_chan - 1) & 8'hFF);
   endfunction

   function automatic void note_off(int n, int vel);
      if (n <= 0) return;
      put_status(mee_pkg::ST_NOTE_OFF); put(n & 127); put(vel & 127);
   endfunction

   function automatic void volume_out(int vol);
      int msb, lsb;
      if (m_note < 0) return;
      msb = shr(vol, mee_pkg::CoarseShiftDefault) & 127;
      if (m_vol_ctrl > 0) begin
         if (m_coarse != msb) begin
            put_status(mee_pkg::ST_CONTROL); put(m_vol_ctrl); put(msb);
         end
         if (m_fine_en != 0) begin
            lsb = shr(vol, mee_pkg::FineShiftDefault) & 127;
            if (m_fine != lsb) begin
               put_status(mee_pkg::ST_CONTROL); put((m_vol_ctrl + 32) & 255); put(lsb);
            end
            m_fine = lsb;
         end
      end else if (m_vol_ctrl == 0) begin
         if (m_coarse != msb) begin
            put_status(mee_pkg::ST_AFTERTOUCH); put(msb);
         end
      end
      m_coarse = msb;
   endfunction

   function automatic void ring_push(int n);
      if (m_rep_en == 0) return;
      m_ring_note[m_wr] = n[7:0];
      m_ring_time[m_wr] = m_time + m_rep_delay;
      m_wr = (m_wr + 1) % mee_pkg::QueueDepthDefault;
   endfunction

   function automatic void predict_bytes(req_word_type e);
      int v, vel, d, val;
      logic [31:0] diff;
      ev_bytes.delete();
      val = e.value;
      case (e.kind)
         mee_pkg::KIND_NOTE_ON: begin
            if (m_override != 0) m_note = e.note;
            else begin
               if (m_note > 0) note_off(m_note, 0);
               v = shr(val, mee_pkg::CoarseShiftDefault) + 1;
               if (v > 127) v = 127;
               volume_out(val);
               vel = (m_fix_vel != 0) ? int'(m_fix_vel) : v;
               put_status(mee_pkg::ST_NOTE_ON); put(e.note); put(vel & 127);
               m_note = e.note;
            end
         end
         mee_pkg::KIND_NOTE_CHANGE: begin
            ring_push(m_note);
            vel = (m_fix_vel != 0) ? int'(m_fix_vel)
                                   : (shr(val, mee_pkg::CoarseShiftDefault) & 127);
            put_status(mee_pkg::ST_NOTE_ON); put(e.note); put(vel & 127);
            note_off(m_note, vel);
            m_note = e.note;
         end
         mee_pkg::KIND_NOTE_OFF: begin
            m_breath = 0;
            volume_out(0);
            note_off(m_note, 0);
            ring_push(m_note);
            m_note = -1;
         end
         mee_pkg::KIND_BREATH: begin
            v = val;
            if (v < 0) v = 0;
            if (v > mee_pkg::VolumeMaxDefault) v = mee_pkg::VolumeMaxDefault;
            m_breath = v;
         end
         mee_pkg::KIND_FLUSH: begin
            if (m_flushed != m_breath) begin
               volume_out(m_breath);
               m_flushed = m_breath;
            end
         end
         mee_pkg::KIND_BEND: begin
            v = val;
            if (v < -8192) v = -8192;
            if (v > 8191) v = 8191;
            if (v != m_bend_in) begin
               m_bend_in = v;
               v += 'h2000;
               if (v != m_bend_sent) begin
                  m_bend_sent = v;
                  put_status(mee_pkg::ST_BEND); put(v & 127); put((v >> 7) & 127);
               end
            end
         end
         mee_pkg::KIND_CONTROLLER: begin
            v = val;
            if (v < 0) v = 0;
            if (v > 127) v = 127;
            put_status(mee_pkg::ST_CONTROL); put(e.ctrl); put(v);
         end
         default: begin
            m_time = m_time + 1;
            if (m_rd != m_wr) begin
               diff = m_time - m_ring_time[m_rd];
               if (!diff[31]) begin
                  d = $signed(m_ring_note[m_rd]);
                  m_rd = (m_rd + 1) % mee_pkg::QueueDepthDefault;
                  if (d != 0 && d != m_note) note_off(d, 0);
               end
            end
         end
      endcase
      if (ev_bytes.size() > 0) ev_bytes[ev_bytes.size() - 1].last = 1'b1;
      foreach (ev_bytes[i]) expected_bytes.push_back(ev_bytes[i]);
   endfunction

   function automatic void model_csr(logic [2:0] idx, logic [15:0] val);
      case (idx)
         mee_pkg::CSR_MIDI_CHANNEL:  m_chan = val[4:0];
         mee_pkg::CSR_VOLUME_CTRL:   m_vol_ctrl = $signed(val[7:0]);
         mee_pkg::CSR_FINE_ENABLE:   m_fine_en = val[0];
         mee_pkg::CSR_FIXED_VEL:     m_fix_vel = val[6:0];
         mee_pkg::CSR_REPEAT_ENABLE: m_rep_en = val[0];
         mee_pkg::CSR_REPEAT_DELAY:  m_rep_delay = val;
         mee_pkg::CSR_OVERRIDE:      m_override = val[0];
         default: ;
      endcase
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // accepted request words, seen at the rising edge
   bit drv_taken = 1'b0;
   always @(posedge clock) begin
      drv_taken <= req_valid && !req_stall;
   end

   // driver
   int           drv_gap = 0;
   req_word_type drv_cur;
   always @(negedge clock) begin
      if (!reset) begin
         if (drv_taken) begin
            predict_bytes(drv_cur);
            if (pending_events.size() > 0 && drv_gap == 0 && $urandom_range(0, 1)) begin
               drv_cur = pending_events.pop_front();
               {req_kind, req_note_number, req_value, req_controller_number} <= drv_cur;
            end else begin
               req_valid <= 1'b0;
               drv_gap = gap_len();
            end
         end else if (!req_valid) begin
            if (drv_gap > 0) drv_gap--;
            else if (pending_events.size() > 0) begin
               drv_cur = pending_events.pop_front();
               {req_kind, req_note_number, req_value, req_controller_number} <= drv_cur;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // stall pattern
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = gap_len();
         rsp_stall <= stall_left > 0;
      end else rsp_stall <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("midi_byte expected none actual %02h", rsp_midi_byte);
            fail_count++;
         end else begin
            exp_w = expected_bytes.pop_front();
            if (exp_w.midi_byte !== rsp_midi_byte) begin
               $error("midi_byte expected %02h actual %02h", exp_w.midi_byte, rsp_midi_byte);
               fail_count++;
            end
            if (exp_w.last !== rsp_last_byte) begin
               $error("last_byte expected %0b actual %0b", exp_w.last, rsp_last_byte);
               fail_count++;
            end
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      model_csr(idx, val);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_events.size() > 0 || req_valid || expected_bytes.size() > 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic req_word_type rand_event();
      req_word_type e;
      int r;
      e.kind = 3'($urandom_range(0, 7));
      e.note = 7'($urandom_range(0, 127));
      e.ctrl = 7'($urandom_range(0, 127));
      r = $urandom_range(0, 9);
      if (r < 2) e.value = 17'($urandom);
      else if (e.kind == mee_pkg::KIND_BEND) e.value = 17'($urandom_range(0, 16383) - 8192);
      else e.value = 17'($urandom_range(0, 65535));
      return e;
   endfunction

   task automatic add(logic [2:0] k, int n, int v, int c);
      pending_events.push_back('{k, n[6:0], v[16:0], c[6:0]});
   endtask

   task automatic random_phase(int n);
      repeat (n) pending_events.push_back(rand_event());
      wait_idle();
   endtask

   initial begin
      m_chan = 1; m_vol_ctrl = 2; m_fine_en = 0; m_fix_vel = 0;
      m_rep_en = 1; m_rep_delay = 1000; m_override = 0;
      m_note = -1; m_breath = 0; m_flushed = 0; m_coarse = 0; m_fine = 0;
      m_bend_in = 0; m_bend_sent = 0; m_time = 0; m_rd = 0; m_wr = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_csr(mee_pkg::CSR_REPEAT_DELAY, 16'd3);
      write_csr(mee_pkg::CSR_FINE_ENABLE, 16'd1);
      // directed
      add(mee_pkg::KIND_FLUSH, 0, 0, 0);
      add(mee_pkg::KIND_BREATH, 0, 65535, 0);
      add(mee_pkg::KIND_NOTE_ON, 60, 65535, 0);
      add(mee_pkg::KIND_FLUSH, 0, 0, 0);
      add(mee_pkg::KIND_BREATH, 0, -8191, 0);
      add(mee_pkg::KIND_FLUSH, 0, 0, 0);
      add(mee_pkg::KIND_NOTE_ON, 0, -8191, 0);
      add(mee_pkg::KIND_NOTE_CHANGE, 127, 40000, 0);
      add(mee_pkg::KIND_NOTE_OFF, 0, 0, 0);
      add(mee_pkg::KIND_BEND, 0, -8191, 0);
      add(mee_pkg::KIND_BEND, 0, 65535, 0);
      add(mee_pkg::KIND_BEND, 0, 65535, 0);
      add(mee_pkg::KIND_BEND, 0, 0, 0);
      add(mee_pkg::KIND_CONTROLLER, 127, -8191, 0);
      add(mee_pkg::KIND_CONTROLLER, 0, 65535, 127);
      repeat (6) add(mee_pkg::KIND_TICK, 0, 0, 0);
      wait_idle();
      write_csr(mee_pkg::CSR_MIDI_CHANNEL, 16'd16);
      write_csr(mee_pkg::CSR_VOLUME_CTRL, 16'd0);
      write_csr(mee_pkg::CSR_FIXED_VEL, 16'd127);
      random_phase(30);
      write_csr(mee_pkg::CSR_MIDI_CHANNEL, 16'd31);
      write_csr(mee_pkg::CSR_VOLUME_CTRL, 16'hFF);
      write_csr(mee_pkg::CSR_OVERRIDE, 16'd1);
      write_csr(mee_pkg::CSR_REPEAT_ENABLE, 16'd0);
      random_phase(30);
      write_csr(mee_pkg::CSR_MIDI_CHANNEL, 16'd0);
      write_csr(mee_pkg::CSR_VOLUME_CTRL, 16'd127);
      write_csr(mee_pkg::CSR_OVERRIDE, 16'd0);
      write_csr(mee_pkg::CSR_REPEAT_ENABLE, 16'd1);
      write_csr(mee_pkg::CSR_FIXED_VEL, 16'd0);
      write_csr(mee_pkg::CSR_REPEAT_DELAY, 16'd0);
      random_phase(45);
      write_csr(mee_pkg::CSR_MIDI_CHANNEL, 16'd1);
      write_csr(mee_pkg::CSR_VOLUME_CTRL, 16'd7);
      write_csr(mee_pkg::CSR_REPEAT_DELAY, 16'hFFFF);
      write_csr(mee_pkg::CSR_FINE_ENABLE, 16'd0);
      random_phase(45);
      if (fail_count == 0 && expected_bytes.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/mee_pkg.sv
hw/rtl/mee_front.sv
hw/rtl/mee_fifo.sv
hw/rtl/mee_back.sv
hw/rtl/midi_event_message_encoder.sv
tb/tb_top.sv
